// File: design/bhq_pkg.sv
package bhq_pkg;

  // Fixed field widths
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 11;
  localparam int SLOT_W  = COUNT_W;
  localparam int LVL_W   = 4;

  typedef enum logic {
    OP_INS = 1'b0,
    OP_DEL = 1'b1
  } bhq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } bhq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_PDATA,
    S_WALK,
    S_RESULT
  } bhq_state_t;

  typedef struct packed {
    bhq_op_t            mode;
    logic [KEY_W-1:0]   key;
  } bhq_in_t;

  typedef struct packed {
    bhq_status_t        status;
    logic [KEY_W-1:0]   removed_key;
    logic [KEY_W-1:0]   min_key;
    logic [COUNT_W-1:0] count;
  } bhq_out_t;

  // Token walking down the level chain.
  // Insert: slot holds the target slot left-aligned (path from root), tlvl its level.
  // Delete: slot holds the hole one level above the receiving cell, key the moving entry.
  typedef struct packed {
    logic              valid;
    bhq_op_t           op;
    logic [SLOT_W-1:0] slot;
    logic [LVL_W-1:0]  tlvl;
    logic [KEY_W-1:0]  key;
  } bhq_tok_t;

  // Write of a slot one level up, from a cell to its upstream neighbor
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } bhq_wb_t;

  // Direct read of one slot (fetch of the last entry)
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } bhq_probe_t;

  // Level (index of the leading one) of a slot number
  function automatic logic [LVL_W-1:0] lvl_of(input logic [SLOT_W-1:0] s);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < SLOT_W; i++) begin
      if (s[i]) begin
        lvl = LVL_W'(i);
      end
    end
    return lvl;
  endfunction

endpackage

// File: design/bhq_cell.sv
module bhq_cell import bhq_pkg::*; #(
  parameter int LEVEL = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] cnt,
  input  bhq_tok_t           tok_i,
  output bhq_tok_t           tok_o,
  input  bhq_wb_t            wb_i,
  output bhq_wb_t            wb_o,
  input  bhq_probe_t         probe_i,
  output logic [KEY_W-1:0]   rdata_o,
  output logic               done_o
);

  bhq_tok_t          tq_r;
  logic              pv_r;
  logic              ph_r;
  logic [KEY_W-1:0]  rd_lo_r;
  logic [KEY_W-1:0]  rd_hi_r;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] ins_node_in;
  logic [SLOT_W-1:0] del_child_in;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [KEY_W-1:0]  wr_key;

  logic              loc_en;
  logic [SLOT_W-1:0] loc_slot;
  logic [KEY_W-1:0]  loc_key;

  logic [SLOT_W-1:0] node_slot;
  logic [KEY_W-1:0]  node_val;
  logic [SLOT_W:0]   cnt_x;
  logic              l_ok;
  logic              r_ok;
  logic              pick_r;
  logic [KEY_W-1:0]  cval;
  logic [SLOT_W-1:0] cslot;
  logic              gc_ok;

  // Read address: probe, insert path node, or the sibling pair under a hole
  assign ins_node_in  = tok_i.slot >> (SLOT_W - 1 - LEVEL);
  assign del_child_in = {tok_i.slot[SLOT_W-2:0], 1'b0};

  always_comb begin
    rd_en   = tok_i.valid || probe_i.en;
    rd_slot = probe_i.en ? probe_i.slot :
              (tok_i.op == OP_INS) ? ins_node_in : del_child_in;
  end

  // One write per cycle: from the downstream cell or from this cell
  always_comb begin
    wr_en   = wb_i.valid || loc_en;
    wr_slot = wb_i.valid ? wb_i.slot : loc_slot;
    wr_key  = wb_i.valid ? wb_i.key  : loc_key;
  end

  // Level storage, rows of sibling pairs
  if (LEVEL < 2) begin : g_reg
    logic [KEY_W-1:0] lo_r;
    logic [KEY_W-1:0] hi_r;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        if (wr_slot[0]) begin
          hi_r <= wr_key;
        end else begin
          lo_r <= wr_key;
        end
      end
      if (rd_en) begin
        rd_lo_r <= lo_r;
        rd_hi_r <= hi_r;
      end
    end
  end else begin : g_mem
    localparam int ROWS = 1 << (LEVEL - 1);
    logic [KEY_W-1:0] lo_mem [ROWS];
    logic [KEY_W-1:0] hi_mem [ROWS];
    logic [LEVEL-2:0] wr_row;
    logic [LEVEL-2:0] rd_row;

    assign wr_row = wr_slot[LEVEL-1:1];
    assign rd_row = rd_slot[LEVEL-1:1];

    always_ff @(posedge clk) begin
      if (wr_en && !wr_slot[0]) begin
        lo_mem[wr_row] <= wr_key;
      end
      if (wr_en && wr_slot[0]) begin
        hi_mem[wr_row] <= wr_key;
      end
      if (rd_en) begin
        rd_lo_r <= lo_mem[rd_row];
        rd_hi_r <= hi_mem[rd_row];
      end
    end
  end

  // Token and probe capture alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tq_r <= '0;
      pv_r <= 1'b0;
    end else begin
      tq_r <= tok_i;
      pv_r <= probe_i.en;
    end
  end

  always_ff @(posedge clk) begin
    ph_r <= probe_i.slot[0];
  end

  assign rdata_o = pv_r ? (ph_r ? rd_hi_r : rd_lo_r) : '0;

  // Compare terms
  assign node_slot = tq_r.slot >> (SLOT_W - 1 - LEVEL);
  assign node_val  = node_slot[0] ? rd_hi_r : rd_lo_r;
  assign cnt_x     = {1'b0, cnt};
  assign l_ok      = {tq_r.slot, 1'b0} <= cnt_x;
  assign r_ok      = {tq_r.slot, 1'b1} <= cnt_x;
  assign pick_r    = r_ok && (rd_hi_r < rd_lo_r);
  assign cval      = pick_r ? rd_hi_r : rd_lo_r;
  assign cslot     = {tq_r.slot[SLOT_W-2:0], pick_r};
  assign gc_ok     = {cslot, 1'b0} <= cnt_x;

  // Per-level step of sift-up (top-down) or sift-down
  always_comb begin
    tok_o    = '0;
    wb_o     = '0;
    loc_en   = 1'b0;
    loc_slot = node_slot;
    loc_key  = tq_r.key;
    done_o   = 1'b0;
    if (tq_r.valid) begin
      case (tq_r.op)
        OP_INS: begin
          if (tq_r.tlvl == LVL_W'(LEVEL)) begin
            // new slot reached: drop the carried key
            loc_en = 1'b1;
            done_o = 1'b1;
          end else begin
            tok_o = tq_r;
            if (tq_r.key < node_val) begin
              // carried key takes this node, old node moves on down
              loc_en    = 1'b1;
              tok_o.key = node_val;
            end
          end
        end
        OP_DEL: begin
          if (LEVEL == 0) begin
            tok_o = tq_r;
          end else if (!l_ok) begin
            wb_o.valid = 1'b1;
            wb_o.slot  = tq_r.slot;
            wb_o.key   = tq_r.key;
            done_o     = 1'b1;
          end else if (cval < tq_r.key) begin
            // smaller child moves up into the hole
            wb_o.valid = 1'b1;
            wb_o.slot  = tq_r.slot;
            wb_o.key   = cval;
            if (gc_ok) begin
              tok_o.valid = 1'b1;
              tok_o.op    = OP_DEL;
              tok_o.slot  = cslot;
              tok_o.tlvl  = tq_r.tlvl;
              tok_o.key   = tq_r.key;
            end else begin
              loc_en   = 1'b1;
              loc_slot = cslot;
              done_o   = 1'b1;
            end
          end else begin
            wb_o.valid = 1'b1;
            wb_o.slot  = tq_r.slot;
            wb_o.key   = tq_r.key;
            done_o     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/binary_min_heap_queue.sv
// Min-heap priority queue of 32-bit unsigned keys, up to CAPACITY entries (2..2047).
// Input channel in_valid/in_ready/in_data: mode insert pushes key, mode delete pops the
// minimum. Result channel out_valid/out_ready/out_data: one result per item with status
// (ok, delete on empty, insert on full), removed key, minimum after the step and count.
// The heap is a chain of level cells, one per tree level, each holding its level in
// sibling-pair rows (registers at levels 0 and 1, a memory below); an operation token
// moves down the chain one level per cycle, each cell registering its read and comparing
// and writing in the next cycle. An insert walks down to the level of the new slot; a
// delete fetches the last entry first, then sifts it down from the root. Refused items
// and the delete of the only entry go straight to the result. One item is in flight at
// a time.
// in_ready is high only while idle. A finished result sits in the output register; the
// next item is taken while it waits. If the receiver still stalls when the following
// result is ready, the block holds that result and takes no input until it moves.
// Reset empties the heap (count zero) and drops any result not yet transferred.
module binary_min_heap_queue import bhq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bhq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bhq_out_t out_data
);

  localparam int NLVL = $clog2(CAPACITY + 1);
  localparam int LVLW = $clog2(NLVL);

  bhq_state_t         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0]   min_r, min_nxt;
  bhq_status_t        status_r, status_nxt;
  logic [KEY_W-1:0]   removed_r, removed_nxt;
  logic [SLOT_W-1:0]  probe_slot_r, probe_slot_nxt;
  logic [LVLW-1:0]    probe_lvl_r, probe_lvl_nxt;
  bhq_tok_t           tok_r, tok_nxt;
  logic               out_valid_r, out_valid_nxt;
  bhq_out_t           out_data_r, out_data_nxt;

  logic               probe_go;
  logic [SLOT_W-1:0]  ins_slot;
  logic [LVL_W-1:0]   ins_lvl;
  logic [LVL_W-1:0]   ins_sh;
  logic [SLOT_W-1:0]  ins_path;
  logic [LVL_W-1:0]   del_lvl;

  bhq_tok_t           tok_dn [NLVL];
  bhq_wb_t            wb_up  [1:NLVL-1];
  bhq_probe_t         probe_c [NLVL];
  logic [KEY_W-1:0]   rdata_c [NLVL];
  logic [NLVL-1:0]    done_v;
  logic [KEY_W-1:0]   probe_data;
  logic               walk_done;

  // Path of the new slot, left-aligned so each level takes a fixed slice
  assign ins_slot = count_r + COUNT_W'(1);
  assign ins_lvl  = lvl_of(ins_slot);
  assign ins_sh   = LVL_W'(SLOT_W - 1) - ins_lvl;
  assign ins_path = ins_slot << ins_sh;
  assign del_lvl  = lvl_of(count_r);

  // Level cells
  assign tok_dn[0] = tok_r;

  for (genvar l = 0; l < NLVL; l++) begin : g_lvl
    assign probe_c[l].en   = probe_go && (probe_lvl_r == LVLW'(l));
    assign probe_c[l].slot = probe_slot_r;

    if (l == 0) begin : g_first
      bhq_cell #(.LEVEL(l)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cnt     (count_r),
        .tok_i   (tok_dn[l]),
        .tok_o   (tok_dn[l+1]),
        .wb_i    (wb_up[l+1]),
        .wb_o    (),
        .probe_i (probe_c[l]),
        .rdata_o (rdata_c[l]),
        .done_o  (done_v[l])
      );
    end else if (l == NLVL - 1) begin : g_last
      bhq_cell #(.LEVEL(l)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cnt     (count_r),
        .tok_i   (tok_dn[l]),
        .tok_o   (),
        .wb_i    ('0),
        .wb_o    (wb_up[l]),
        .probe_i (probe_c[l]),
        .rdata_o (rdata_c[l]),
        .done_o  (done_v[l])
      );
    end else begin : g_mid
      bhq_cell #(.LEVEL(l)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cnt     (count_r),
        .tok_i   (tok_dn[l]),
        .tok_o   (tok_dn[l+1]),
        .wb_i    (wb_up[l+1]),
        .wb_o    (wb_up[l]),
        .probe_i (probe_c[l]),
        .rdata_o (rdata_c[l]),
        .done_o  (done_v[l])
      );
    end
  end

  // Only the probed cell drives its read data
  always_comb begin
    probe_data = '0;
    for (int i = 0; i < NLVL; i++) begin
      probe_data = probe_data | rdata_c[i];
    end
  end

  assign walk_done = |done_v;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    min_nxt        = min_r;
    status_nxt     = status_r;
    removed_nxt    = removed_r;
    probe_slot_nxt = probe_slot_r;
    probe_lvl_nxt  = probe_lvl_r;
    tok_nxt        = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    in_ready       = 1'b0;
    probe_go       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          removed_nxt = '0;
          status_nxt  = ST_OK;
          case (in_data.mode)
            OP_INS: begin
              if (count_r == COUNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESULT;
              end else begin
                count_nxt     = ins_slot;
                tok_nxt.valid = 1'b1;
                tok_nxt.op    = OP_INS;
                tok_nxt.slot  = ins_path;
                tok_nxt.tlvl  = ins_lvl;
                tok_nxt.key   = in_data.key;
                if (count_r == '0 || in_data.key < min_r) begin
                  min_nxt = in_data.key;
                end
                state_nxt = S_WALK;
              end
            end
            OP_DEL: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESULT;
              end else begin
                removed_nxt = min_r;
                count_nxt   = count_r - COUNT_W'(1);
                if (count_r == COUNT_W'(1)) begin
                  state_nxt = S_RESULT;
                end else begin
                  probe_slot_nxt = count_r;
                  probe_lvl_nxt  = LVLW'(del_lvl);
                  state_nxt      = S_PROBE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PROBE: begin
        // fetch the last entry, it refills the root
        probe_go  = 1'b1;
        state_nxt = S_PDATA;
      end
      S_PDATA: begin
        tok_nxt.valid = 1'b1;
        tok_nxt.op    = OP_DEL;
        tok_nxt.slot  = SLOT_W'(1);
        tok_nxt.tlvl  = '0;
        tok_nxt.key   = probe_data;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        // root rewrites during sift-down come from level one
        if (wb_up[1].valid) begin
          min_nxt = wb_up[1].key;
        end
        if (walk_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.removed_key = removed_r;
          out_data_nxt.min_key     = (count_r == '0) ? '0 : min_r;
          out_data_nxt.count       = count_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tok_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tok_r       <= tok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    min_r        <= min_nxt;
    status_r     <= status_nxt;
    removed_r    <= removed_nxt;
    probe_slot_r <= probe_slot_nxt;
    probe_lvl_r  <= probe_lvl_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: test/tb_binary_min_heap_queue.sv
module tb_binary_min_heap_queue import bhq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_SLOTS     = 1024;
  localparam int RANDOM_ITEMS   = 930;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // Mirror of the heap: predicts each reply and matches replies in order
  class heap_mirror;
    logic [KEY_W-1:0] keys [1:HEAP_SLOTS];
    int               fill;
    bhq_out_t         awaited_replies[$];
    int               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the mirror and queue the reply it yields
    function void heap_step(bhq_in_t req);
      bhq_out_t         reply;
      int               hole;
      int               child;
      logic [KEY_W-1:0] moving;
      reply        = '0;
      reply.status = ST_OK;
      if (req.mode == OP_INS) begin
        if (fill >= HEAP_SLOTS) begin
          reply.status = ST_FULL;
        end else begin
          // sift up: stop below an equal parent
          fill++;
          hole = fill;
          while (hole > 1 && req.key < keys[hole / 2]) begin
            keys[hole] = keys[hole / 2];
            hole       = hole / 2;
          end
          keys[hole] = req.key;
        end
      end else begin
        if (fill == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.removed_key = keys[1];
          keys[1] = keys[fill];
          fill--;
          if (fill > 0) begin
            // sift down: left child wins ties, equal child stays put
            hole   = 1;
            moving = keys[1];
            while (hole * 2 <= fill) begin
              child = hole * 2;
              if (child != fill && keys[child + 1] < keys[child]) begin
                child++;
              end
              if (keys[child] < moving) begin
                keys[hole] = keys[child];
                hole       = child;
              end else begin
                break;
              end
            end
            keys[hole] = moving;
          end
        end
      end
      reply.min_key = (fill > 0) ? keys[1] : '0;
      reply.count   = COUNT_W'(fill);
      awaited_replies.push_back(reply);
    endfunction

    // Compare one transferred reply with the oldest prediction
    function void check_reply(bhq_out_t got);
      bhq_out_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply status %0d removed %h min %h count %0d",
                 $time, got.status, got.removed_key, got.min_key, got.count);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.removed_key !== want.removed_key) begin
        $display("%0t: removed_key expected %h actual %h",
                 $time, want.removed_key, got.removed_key);
        errors++;
      end
      if (got.min_key !== want.min_key) begin
        $display("%0t: min_key expected %h actual %h", $time, want.min_key, got.min_key);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bhq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bhq_out_t out_data;

  heap_mirror mirror;

  int send_calm;
  int recv_calm;
  int idle_cycles;

  binary_min_heap_queue #(.CAPACITY(HEAP_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bhq_in_t make_item(bhq_op_t op, logic [KEY_W-1:0] key);
    bhq_in_t req;
    req.mode = op;
    req.key  = key;
    return req;
  endfunction

  // Mix of wide keys, narrow keys (many duplicates) and corner values
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] key;
    case ($urandom_range(0, 5))
      0: key = KEY_W'($urandom_range(0, 15));
      1: begin
        case ($urandom_range(0, 3))
          0: key = '0;
          1: key = '1;
          2: key = 32'h8000_0000;
          default: key = 32'h7FFF_FFFF;
        endcase
      end
      2: key = KEY_W'($urandom_range(0, 255));
      default: key = $urandom;
    endcase
    return key;
  endfunction

  // Wait length per transfer, 0..7, with occasional runs of back-to-back traffic
  task automatic draw_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) begin
        calm = $urandom_range(10, 40);
      end
      cycles = $urandom_range(0, 7);
    end
  endtask

  // Drive one request; called at a falling edge, returns at a falling edge
  task automatic push_item(bhq_in_t req);
    int gap;
    draw_wait(send_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    mirror.heap_step(req);
    @(negedge clk);
  endtask

  // Reply side: random stalls, check every transfer
  initial begin
    int gap;
    out_ready = 1'b0;
    recv_calm = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      draw_wait(recv_calm, gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      mirror.check_reply(out_data);
      @(negedge clk);
    end
  end

  // Watchdog: too long without any transfer
  initial begin
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    bhq_in_t script[$];
    int      insert_pct;
    mirror    = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    send_calm = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty delete, extreme keys, last-entry delete, equal keys
    script.push_back(make_item(OP_DEL, '1));
    script.push_back(make_item(OP_INS, '1));
    script.push_back(make_item(OP_INS, '0));
    script.push_back(make_item(OP_DEL, $urandom));
    script.push_back(make_item(OP_DEL, $urandom));
    script.push_back(make_item(OP_DEL, '0));
    script.push_back(make_item(OP_INS, 32'd7));
    script.push_back(make_item(OP_INS, 32'd7));
    script.push_back(make_item(OP_INS, 32'd7));
    script.push_back(make_item(OP_INS, 32'h8000_0000));
    script.push_back(make_item(OP_INS, 32'h7FFF_FFFF));
    script.push_back(make_item(OP_INS, 32'd1));
    script.push_back(make_item(OP_INS, 32'd7));
    repeat (7) script.push_back(make_item(OP_DEL, $urandom));
    foreach (script[i]) push_item(script[i]);

    // Random mix; insert share changes every 50 items to move the fill level around
    insert_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        push_item(make_item(OP_INS, rand_key()));
      end else begin
        push_item(make_item(OP_DEL, $urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding replies, then watch for strays
    while (mirror.awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bhq_pkg.sv
design/bhq_cell.sv
design/binary_min_heap_queue.sv
test/tb_binary_min_heap_queue.sv
